### hw/rtl/dblp_pkg.sv
package dblp_pkg;

  // Parser phases
  localparam logic [3:0] PH_START  = 4'd0;
  localparam logic [3:0] PH_SPACE  = 4'd1;
  localparam logic [3:0] PH_SIGN   = 4'd2;
  localparam logic [3:0] PH_ZERO   = 4'd3;
  localparam logic [3:0] PH_XLOW   = 4'd4;
  localparam logic [3:0] PH_XUP    = 4'd5;
  localparam logic [3:0] PH_DIGITS = 4'd6;
  localparam logic [3:0] PH_DELIM  = 4'd7;
  localparam logic [3:0] PH_HALT   = 4'd8;

  // Final status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_ONE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_TWO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_THREE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_FOUR   = 3'd6;

  // Register reset values
  localparam logic [5:0] RST_NUMBER_BASE = 6'd0;
  localparam logic [7:0] RST_MAX_COUNT   = 8'd255;
  localparam logic [2:0] RST_DELIM_COUNT = 3'd2;
  localparam logic [7:0] RST_DELIM_ONE   = 8'd58;
  localparam logic [7:0] RST_DELIM_TWO   = 8'd45;
  localparam logic [7:0] RST_DELIM_THREE = 8'd0;
  localparam logic [7:0] RST_DELIM_FOUR  = 8'd0;

  localparam logic [5:0] BASE_DEC     = 6'd10;
  localparam logic [5:0] BASE_HEX     = 6'd16;
  localparam logic [5:0] BASE_MAX     = 6'd36;
  localparam logic [5:0] DIGIT_NONE   = 6'd36;
  localparam logic [2:0] NUM_DELIMS   = 3'd4;
  localparam logic [8:0] ACC_OVERFLOW = 9'd256;

  localparam logic [7:0] CHAR_NUL    = 8'd0;
  localparam logic [7:0] CHAR_SPACE  = 8'd32;
  localparam logic [7:0] CHAR_TAB    = 8'd9;
  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_PLUS   = 8'd43;
  localparam logic [7:0] CHAR_MINUS  = 8'd45;
  localparam logic [7:0] CHAR_ZERO   = 8'd48;
  localparam logic [7:0] CHAR_NINE   = 8'd57;
  localparam logic [7:0] CHAR_UP_A   = 8'd65;
  localparam logic [7:0] CHAR_UP_X   = 8'd88;
  localparam logic [7:0] CHAR_UP_Z   = 8'd90;
  localparam logic [7:0] CHAR_LOW_A  = 8'd97;
  localparam logic [7:0] CHAR_LOW_X  = 8'd120;
  localparam logic [7:0] CHAR_LOW_Z  = 8'd122;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [5:0]      number_base;
    logic [7:0]      max_count;
    logic [2:0]      delim_count;
    logic [3:0][7:0] delim;
  } cfg_t;

  // One classified character
  typedef struct packed {
    logic [5:0] dig;
    logic       is_nul;
    logic       is_space;
    logic       is_sign;
    logic       is_minus;
    logic       is_delim;
    logic       is_zero;
    logic       is_x_low;
    logic       is_x_up;
  } cls_t;

  function automatic logic delim_match(logic [7:0] c, cfg_t cfg);
    logic [2:0] n;
    logic       hit;
    n   = (cfg.delim_count > NUM_DELIMS) ? NUM_DELIMS : cfg.delim_count;
    hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if ((3'(i) < n) && (c == cfg.delim[i])) begin
        hit = 1'b1;
      end
    end
    return hit && (c != CHAR_NUL);
  endfunction

endpackage

### hw/rtl/dblp_text_if.sv
interface dblp_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;

  modport source (output valid, output text_char, input ready);
  modport sink   (input valid, input text_char, output ready);
endinterface

### hw/rtl/dblp_res_if.sv
interface dblp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       byte_valid;
  logic       done_res;
  logic [1:0] status;
  logic [7:0] byte_count;

  modport source (
    output valid, output byte_value, output byte_valid, output done_res,
    output status, output byte_count, input ready
  );
  modport sink (
    input valid, input byte_value, input byte_valid, input done_res,
    input status, input byte_count, output ready
  );
endinterface

### hw/rtl/dblp_front.sv
module dblp_front
  import dblp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  dblp_text_if.sink   text_in,
  output logic        q_valid_o,
  output cls_t        q_data_o,
  input  logic        q_pop_i
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  cls_t          mem_q [QUEUE_DEPTH];
  cls_t          cls;
  logic          push, pop;
  logic [7:0]    c;

  // Classify the incoming character
  always_comb begin
    c = text_in.text_char;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      cls.dig = 6'(c - CHAR_ZERO);
    end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
      cls.dig = 6'(c - CHAR_LOW_A + 8'd10);
    end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      cls.dig = 6'(c - CHAR_UP_A + 8'd10);
    end else begin
      cls.dig = DIGIT_NONE;
    end
    cls.is_nul   = (c == CHAR_NUL);
    cls.is_space = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    cls.is_sign  = (c == CHAR_PLUS) || (c == CHAR_MINUS);
    cls.is_minus = (c == CHAR_MINUS);
    cls.is_delim = delim_match(c, cfg_i);
    cls.is_zero  = (c == CHAR_ZERO);
    cls.is_x_low = (c == CHAR_LOW_X);
    cls.is_x_up  = (c == CHAR_UP_X);
  end

  assign text_in.ready = (cnt_q != CW'(QUEUE_DEPTH));
  assign push          = text_in.valid && text_in.ready;
  assign q_valid_o     = (cnt_q != '0);
  assign pop           = q_pop_i && q_valid_o;
  assign q_data_o      = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cls;
    end
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CW'(QUEUE_DEPTH)) && !(push && cnt_q == CW'(QUEUE_DEPTH)))
    else $error("character queue overrun");
`endif

endmodule

### hw/rtl/dblp_back.sv
module dblp_back
  import dblp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  input  cls_t        q_data_i,
  output logic        q_pop_o,
  dblp_res_if.source  res_out
);

  logic [3:0] phase_q, phase_d;
  logic [8:0] acc_q, acc_d;
  logic       ovf_q, ovf_d, neg_q, neg_d;
  logic [5:0] base_q, base_d;
  logic [7:0] bytes_q, bytes_d;
  logic [1:0] err_q, err_d;

  logic       out_valid_q;
  logic [7:0] out_val_q, out_cnt_q;
  logic       out_bv_q, out_done_q;
  logic [1:0] out_st_q;

  logic       adv;
  logic       emit, e_bv, e_done;
  logic [7:0] e_val, e_cnt;
  logic [1:0] e_st;
  logic       delim_x_low, delim_x_up;

  assign adv     = q_valid_i && (!out_valid_q || res_out.ready);
  assign q_pop_o = adv;

  assign delim_x_low = delim_match(CHAR_LOW_X, cfg_i);
  assign delim_x_up  = delim_match(CHAR_UP_X, cfg_i);

  always_comb begin
    logic       do_lead, do_begin, do_end, do_after, do_fin, fin_vld, vok;
    logic [7:0] fin_val;
    logic [5:0] b;
    logic [15:0] prod;
    cls_t       k;

    k        = q_data_i;
    phase_d  = phase_q;
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    neg_d    = neg_q;
    base_d   = base_q;
    bytes_d  = bytes_q;
    err_d    = err_q;
    do_lead  = 1'b0;
    do_begin = 1'b0;
    do_end   = 1'b0;
    do_after = 1'b0;
    do_fin   = 1'b0;
    fin_vld  = 1'b0;
    fin_val  = '0;
    emit     = 1'b0;
    e_val    = '0;
    e_bv     = 1'b0;
    e_done   = 1'b0;
    e_st     = ST_OK;
    e_cnt    = bytes_q;
    b        = '0;
    prod     = 16'(acc_q) * 16'(base_q) + 16'(k.dig);

    unique case (phase_q)
      PH_START: begin
        if (k.is_nul) do_fin = 1'b1;
        else do_begin = 1'b1;
      end
      PH_SPACE, PH_SIGN: begin
        if (k.is_nul) begin
          err_d = ST_INVALID; phase_d = PH_HALT; do_fin = 1'b1;
        end else begin
          do_lead = 1'b1;
        end
      end
      PH_ZERO: begin
        if (base_q == '0 && k.is_x_low) begin
          base_d = BASE_HEX; phase_d = PH_XLOW;
        end else if (base_q == BASE_HEX && (k.is_x_low || k.is_x_up)) begin
          phase_d = k.is_x_low ? PH_XLOW : PH_XUP;
        end else begin
          if (base_q == '0) base_d = BASE_DEC;
          // accumulator is zero here, so the new value is the digit itself
          if (k.dig < base_d) begin
            acc_d = 9'(k.dig); phase_d = PH_DIGITS;
          end else begin
            do_end = 1'b1;
          end
        end
      end
      PH_DIGITS: begin
        if (k.dig < base_q) begin
          if (ovf_q || prod > 16'd255) begin
            ovf_d = 1'b1; acc_d = ACC_OVERFLOW;
          end else begin
            acc_d = 9'(prod);
          end
        end else begin
          do_end = 1'b1;
        end
      end
      PH_XLOW, PH_XUP: begin
        if (k.dig < BASE_HEX) begin
          acc_d = 9'(k.dig); phase_d = PH_DIGITS;
        end else if (!((phase_q == PH_XLOW) ? delim_x_low : delim_x_up)) begin
          err_d = ST_INVALID; phase_d = PH_HALT;
          if (k.is_nul) do_fin = 1'b1;
        end else begin
          phase_d = PH_DELIM; do_after = 1'b1;
        end
      end
      PH_DELIM: do_after = 1'b1;
      default: begin
        if (k.is_nul) begin
          if (err_q == ST_OK) err_d = ST_INVALID;
          do_fin = 1'b1;
        end
      end
    endcase

    vok = !ovf_d && !(neg_d && acc_d != '0);

    // token ended by a non-digit
    if (do_end) begin
      if (k.is_nul) begin
        if (!vok) begin
          err_d = ST_INVALID; phase_d = PH_HALT; do_fin = 1'b1;
        end else begin
          bytes_d = bytes_d + 1'b1;
          do_fin  = 1'b1; fin_vld = 1'b1; fin_val = acc_d[7:0];
        end
      end else if (k.is_delim) begin
        phase_d = PH_DELIM;
      end else begin
        err_d = ST_INVALID; phase_d = PH_HALT;
      end
    end

    // character after a delimiter confirms the previous byte
    if (do_after) begin
      if (k.is_nul) begin
        err_d = ST_INVALID; phase_d = PH_HALT; do_fin = 1'b1;
      end else if (k.is_delim || !vok) begin
        err_d = ST_INVALID; phase_d = PH_HALT;
      end else begin
        bytes_d = bytes_d + 1'b1;
        emit    = 1'b1; e_val = acc_d[7:0]; e_bv = 1'b1; e_cnt = bytes_d;
        do_begin = 1'b1;
      end
    end

    if (do_begin) begin
      if (bytes_d >= cfg_i.max_count) begin
        err_d = ST_RANGE; phase_d = PH_HALT;
      end else if (cfg_i.number_base == 6'd1 || cfg_i.number_base > BASE_MAX) begin
        err_d = ST_INVALID; phase_d = PH_HALT;
      end else begin
        acc_d = '0; ovf_d = 1'b0; neg_d = 1'b0;
        base_d = cfg_i.number_base; phase_d = PH_START;
        do_lead = 1'b1;
      end
    end

    // leading part of a token: white space, sign, first digit
    if (do_lead) begin
      b = (base_d == '0) ? BASE_DEC : base_d;
      if (phase_d != PH_SIGN && k.is_space) begin
        if (base_d == '0) base_d = BASE_DEC;
        phase_d = PH_SPACE;
      end else if (phase_d != PH_SIGN && k.is_sign) begin
        neg_d = k.is_minus; phase_d = PH_SIGN;
      end else if (k.is_zero && (base_d == '0 || base_d == BASE_HEX)) begin
        acc_d = '0; phase_d = PH_ZERO;
      end else if (k.dig < b) begin
        base_d = b; acc_d = 9'(k.dig); phase_d = PH_DIGITS;
      end else begin
        err_d = ST_INVALID; phase_d = PH_HALT;
      end
    end

    if (do_fin) begin
      emit    = 1'b1;
      e_val   = fin_val;
      e_bv    = fin_vld;
      e_done  = 1'b1;
      e_st    = err_d;
      e_cnt   = bytes_d;
      phase_d = PH_START;
      acc_d   = '0;
      ovf_d   = 1'b0;
      neg_d   = 1'b0;
      base_d  = BASE_DEC;
      bytes_d = '0;
      err_d   = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      neg_q       <= 1'b0;
      base_q      <= BASE_DEC;
      bytes_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        ovf_q   <= ovf_d;
        neg_q   <= neg_d;
        base_q  <= base_d;
        bytes_q <= bytes_d;
        err_q   <= err_d;
      end
      if (adv && emit) begin
        out_valid_q <= 1'b1;
      end else if (res_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      out_val_q  <= e_val;
      out_bv_q   <= e_bv;
      out_done_q <= e_done;
      out_st_q   <= e_st;
      out_cnt_q  <= e_cnt;
    end
  end

  assign res_out.valid      = out_valid_q;
  assign res_out.byte_value = out_val_q;
  assign res_out.byte_valid = out_bv_q;
  assign res_out.done_res   = out_done_q;
  assign res_out.status     = out_st_q;
  assign res_out.byte_count = out_cnt_q;

`ifndef SYNTHESIS
  a_clear_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && emit && e_done) |=>
      (phase_q == PH_START && bytes_q == '0 && err_q == ST_OK))
    else $error("string state not cleared after final result");
  a_overflow_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (acc_q == ACC_OVERFLOW))
    else $error("overflowed accumulator not saturated");
`endif

endmodule

### hw/rtl/delimited_byte_list_parser_top.sv
// Delimited byte list parser.
// text_in carries one character per transfer (valid/ready); a NUL ends the
// string. res_out carries zero or one result per character: a parsed byte
// once the character after its delimiter confirms it, and a final result
// for the NUL with status (ok, invalid text, too many bytes) and the count.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 base, 1 max count, 2 delimiter count, 3..6 delimiter characters);
// write only while no string is in flight.
// Each character is queued as a classified character; the parser state then
// takes it from the queue and loads any result into the output register.
// Throughput: one character per cycle while res_out does not stall; the
// parser state update (digit multiply-add) runs as each character leaves the queue.
// A small classified-character queue sits between front and back, and an
// output register holds a result while res_out stalls; when both fill,
// text_in.ready drops. Reset empties the queue and the output register,
// returns the parser to the start of a string and loads register defaults.
module delimited_byte_list_parser_top
  import dblp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dblp_text_if.sink             text_in,
  dblp_res_if.source            res_out,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic q_valid, q_pop;
  cls_t q_data;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.number_base <= RST_NUMBER_BASE;
      cfg_q.max_count   <= RST_MAX_COUNT;
      cfg_q.delim_count <= RST_DELIM_COUNT;
      cfg_q.delim[0]    <= RST_DELIM_ONE;
      cfg_q.delim[1]    <= RST_DELIM_TWO;
      cfg_q.delim[2]    <= RST_DELIM_THREE;
      cfg_q.delim[3]    <= RST_DELIM_FOUR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUMBER_BASE: cfg_q.number_base <= cfg_data_i[5:0];
        CFG_MAX_COUNT:   cfg_q.max_count   <= cfg_data_i;
        CFG_DELIM_COUNT: cfg_q.delim_count <= cfg_data_i[2:0];
        CFG_DELIM_ONE:   cfg_q.delim[0]    <= cfg_data_i;
        CFG_DELIM_TWO:   cfg_q.delim[1]    <= cfg_data_i;
        CFG_DELIM_THREE: cfg_q.delim[2]    <= cfg_data_i;
        CFG_DELIM_FOUR:  cfg_q.delim[3]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: classify characters and queue them
  dblp_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .text_in  (text_in),
    .q_valid_o(q_valid),
    .q_data_o (q_data),
    .q_pop_i  (q_pop)
  );

  // Back: run the token parser and hold results in the output register
  dblp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .q_valid_i(q_valid),
    .q_data_i (q_data),
    .q_pop_o  (q_pop),
    .res_out  (res_out)
  );

`ifndef SYNTHESIS
  a_error_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_out.valid && (res_out.status != ST_OK)) |->
      (res_out.done_res && !res_out.byte_valid))
    else $error("error status on a result that is not final or carries a byte");
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_out.valid && !res_out.done_res) |-> res_out.byte_valid)
    else $error("intermediate result without a byte");
`endif

endmodule

### verif/dblp_checker.sv
`timescale 1ns / 1ps

module dblp_checker
  import dblp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dblp_text_if                  text_in,
  dblp_res_if                   res_out,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_valid;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] byte_count;
  } parse_result_t;

  // Register mirror
  logic [5:0] base_reg;
  logic [7:0] max_reg;
  logic [2:0] nsep_reg;
  logic [7:0] sep_reg [4];

  // Parser state mirror
  logic [3:0] phase;
  logic [8:0] acc;
  logic       acc_ovf;
  logic       minus;
  logic [5:0] tok_base;
  logic [7:0] nbytes;
  logic [1:0] err;

  parse_result_t parsed_q [$];

  function automatic void restart_line();
    phase    = PH_START;
    acc      = '0;
    acc_ovf  = 1'b0;
    minus    = 1'b0;
    tok_base = BASE_DEC;
    nbytes   = '0;
    err      = ST_OK;
  endfunction

  function automatic void halt_with(logic [1:0] code);
    err   = code;
    phase = PH_HALT;
  endfunction

  function automatic logic is_sep(logic [7:0] c);
    int n;
    n = (nsep_reg > NUM_DELIMS) ? int'(NUM_DELIMS) : int'(nsep_reg);
    if (c == CHAR_NUL) return 1'b0;
    for (int i = 0; i < n; i++) begin
      if (c == sep_reg[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  function automatic int digit_val(logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c) - int'(CHAR_ZERO);
    if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) return int'(c) - int'(CHAR_LOW_A) + 10;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) return int'(c) - int'(CHAR_UP_A) + 10;
    return int'(DIGIT_NONE);
  endfunction

  function automatic parse_result_t make_result(logic [7:0] v, logic bv, logic dn);
    parse_result_t r;
    r.byte_value = v;
    r.byte_valid = bv;
    r.done_res   = dn;
    r.status     = dn ? err : ST_OK;
    r.byte_count = nbytes;
    return r;
  endfunction

  // Saturate at 256 once the value leaves the byte range
  function automatic void add_digit(int d);
    int v;
    v = int'(acc) * int'(tok_base) + d;
    if (acc_ovf || v > 255) begin
      acc_ovf = 1'b1;
      v       = int'(ACC_OVERFLOW);
    end
    acc   = 9'(v);
    phase = PH_DIGITS;
  endfunction

  function automatic logic value_fits();
    return !acc_ovf && !(minus && acc != '0);
  endfunction

  // White space, sign and first digit of a token
  function automatic void lead_char(logic [7:0] c);
    int b;
    int d;
    b = (tok_base == '0) ? int'(BASE_DEC) : int'(tok_base);
    d = digit_val(c);
    if (phase != PH_SIGN && is_ws(c)) begin
      if (tok_base == '0) tok_base = BASE_DEC;
      phase = PH_SPACE;
    end else if (phase != PH_SIGN && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
      minus = (c == CHAR_MINUS);
      phase = PH_SIGN;
    end else if (c == CHAR_ZERO && (tok_base == '0 || tok_base == BASE_HEX)) begin
      acc   = '0;
      phase = PH_ZERO;
    end else if (d < b) begin
      tok_base = 6'(b);
      acc      = '0;
      add_digit(d);
    end else begin
      halt_with(ST_INVALID);
    end
  endfunction

  function automatic void start_token(logic [7:0] c);
    if (nbytes >= max_reg) begin
      halt_with(ST_RANGE);
      return;
    end
    if (base_reg == 6'd1 || base_reg > BASE_MAX) begin
      halt_with(ST_INVALID);
      return;
    end
    acc      = '0;
    acc_ovf  = 1'b0;
    minus    = 1'b0;
    tok_base = base_reg;
    phase    = PH_START;
    lead_char(c);
  endfunction

  // Character after a delimiter: it confirms the pending byte or breaks the list
  function automatic bit past_sep(logic [7:0] c, output parse_result_t r);
    logic [7:0] v;
    v = acc[7:0];
    if (c == CHAR_NUL) begin
      halt_with(ST_INVALID);
      r = make_result('0, 1'b0, 1'b1);
      restart_line();
      return 1'b1;
    end
    if (is_sep(c) || !value_fits()) begin
      halt_with(ST_INVALID);
      return 1'b0;
    end
    nbytes++;
    r = make_result(v, 1'b1, 1'b0);
    start_token(c);
    return 1'b1;
  endfunction

  function automatic bit close_token(logic [7:0] c, output parse_result_t r);
    if (c == CHAR_NUL) begin
      if (!value_fits()) begin
        halt_with(ST_INVALID);
        r = make_result('0, 1'b0, 1'b1);
      end else begin
        nbytes++;
        r = make_result(acc[7:0], 1'b1, 1'b1);
      end
      restart_line();
      return 1'b1;
    end
    if (is_sep(c)) phase = PH_DELIM;
    else halt_with(ST_INVALID);
    return 1'b0;
  endfunction

  function automatic bit parse_char(logic [7:0] c, output parse_result_t r);
    int d;
    d = digit_val(c);
    case (phase)
      PH_START: begin
        if (c == CHAR_NUL) begin
          r = make_result('0, 1'b0, 1'b1);
          restart_line();
          return 1'b1;
        end
        start_token(c);
        return 1'b0;
      end
      PH_SPACE, PH_SIGN: begin
        if (c == CHAR_NUL) begin
          halt_with(ST_INVALID);
          r = make_result('0, 1'b0, 1'b1);
          restart_line();
          return 1'b1;
        end
        lead_char(c);
        return 1'b0;
      end
      PH_ZERO: begin
        if (tok_base == '0) begin
          if (c == CHAR_LOW_X) begin
            tok_base = BASE_HEX;
            phase    = PH_XLOW;
            return 1'b0;
          end
          tok_base = BASE_DEC;
        end else if (tok_base == BASE_HEX && (c == CHAR_LOW_X || c == CHAR_UP_X)) begin
          phase = (c == CHAR_LOW_X) ? PH_XLOW : PH_XUP;
          return 1'b0;
        end
        if (d < tok_base) begin
          add_digit(d);
          return 1'b0;
        end
        return close_token(c, r);
      end
      PH_DIGITS: begin
        if (d < tok_base) begin
          add_digit(d);
          return 1'b0;
        end
        return close_token(c, r);
      end
      PH_XLOW, PH_XUP: begin
        if (d < 16) begin
          add_digit(d);
          return 1'b0;
        end
        // a bare prefix reads as zero; the x must then be a delimiter
        if (!is_sep((phase == PH_XLOW) ? CHAR_LOW_X : CHAR_UP_X)) begin
          halt_with(ST_INVALID);
          if (c == CHAR_NUL) begin
            r = make_result('0, 1'b0, 1'b1);
            restart_line();
            return 1'b1;
          end
          return 1'b0;
        end
        phase = PH_DELIM;
        return past_sep(c, r);
      end
      PH_DELIM: return past_sep(c, r);
      default: begin
        if (c == CHAR_NUL) begin
          if (err == ST_OK) err = ST_INVALID;
          r = make_result('0, 1'b0, 1'b1);
          restart_line();
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    parse_result_t got;
    parse_result_t want;
    if (!rst_ni) begin
      base_reg   = RST_NUMBER_BASE;
      max_reg    = RST_MAX_COUNT;
      nsep_reg   = RST_DELIM_COUNT;
      sep_reg[0] = RST_DELIM_ONE;
      sep_reg[1] = RST_DELIM_TWO;
      sep_reg[2] = RST_DELIM_THREE;
      sep_reg[3] = RST_DELIM_FOUR;
      restart_line();
      parsed_q.delete();
      mismatch_count_o = 0;
    end else begin
      if (res_out.valid && res_out.ready) begin
        got = '{res_out.byte_value, res_out.byte_valid, res_out.done_res,
                res_out.status, res_out.byte_count};
        if (parsed_q.size() == 0) begin
          $display("%0t: result with none expected, got %p", $time, got);
          mismatch_count_o++;
        end else begin
          want = parsed_q.pop_front();
          check_field("byte_value", want.byte_value, got.byte_value);
          check_field("byte_valid", want.byte_valid, got.byte_valid);
          check_field("done_res", want.done_res, got.done_res);
          check_field("status", want.status, got.status);
          check_field("byte_count", want.byte_count, got.byte_count);
        end
      end
      if (text_in.valid && text_in.ready) begin
        if (parse_char(text_in.text_char, want)) parsed_q.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUMBER_BASE: base_reg   = cfg_data_i[5:0];
          CFG_MAX_COUNT:   max_reg    = cfg_data_i;
          CFG_DELIM_COUNT: nsep_reg   = cfg_data_i[2:0];
          CFG_DELIM_ONE:   sep_reg[0] = cfg_data_i;
          CFG_DELIM_TWO:   sep_reg[1] = cfg_data_i;
          CFG_DELIM_THREE: sep_reg[2] = cfg_data_i;
          CFG_DELIM_FOUR:  sep_reg[3] = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = parsed_q.size();
  end

endmodule

### verif/tb_delimited_byte_list_parser_top.sv
`timescale 1ns / 1ps

module tb_delimited_byte_list_parser_top;
  import dblp_pkg::*;

  // Stop once about this many characters have been transferred
  localparam int unsigned TOTAL_CHARS = 1850;
  // Characters per register setting
  localparam int unsigned SETTING_CHARS = 150;
  // Cycles with no transfer and no register write before giving up
  localparam int unsigned IDLE_LIMIT = 1000;
  // Results lag their characters through the queue and output register; leave some slack
  localparam int unsigned SETTLE_CYCLES = 4;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned mismatch_count;
  int unsigned pending;
  int unsigned chars_sent;
  int unsigned idle_cycles;

  // When set, the side runs without gaps
  bit tx_steady;
  bit rx_steady;

  // Settings as currently written, used to shape the text
  logic [5:0] cur_radix;
  logic [7:0] cur_max;
  logic [2:0] cur_nsep;
  logic [7:0] cur_sep [4];

  // Text of the line being built
  logic [7:0] line_q [$];

  dblp_text_if txt ();
  dblp_res_if  res ();

  delimited_byte_list_parser_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .text_in    (txt),
    .res_out    (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  dblp_checker parse_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .text_in          (txt),
    .res_out          (res),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: any transfer or register write counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (txt.valid && txt.ready) || (res.valid && res.ready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: draw a stall per result, drop ready during it, then hold
  // ready until a transfer happens. Toggle into and out of steady stretches.
  initial begin
    int stall;
    res.ready <= 1'b0;
    rx_steady = 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!res.valid);
    end
  end

  // Send one character: optional gap with valid low, then hold valid
  // until the parser takes the transfer.
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      txt.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    txt.valid     <= 1'b1;
    txt.text_char <= c;
    do @(posedge clk_i); while (!txt.ready);
    chars_sent++;
  endtask

  task automatic send_text(input string text);
    foreach (text[i]) send_char(text[i]);
    send_char(CHAR_NUL);
  endtask

  // Drop valid, wait for every predicted result, then let the pipe drain
  // so a register write never lands on a character in flight.
  task automatic settle();
    txt.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all seven registers on consecutive edges
  task automatic write_config(input logic [5:0] base, input logic [7:0] maxc,
                              input logic [2:0] nsep, input logic [7:0] s0,
                              input logic [7:0] s1, input logic [7:0] s2,
                              input logic [7:0] s3);
    logic [CFG_IDX_W-1:0]  idx  [7];
    logic [CFG_DATA_W-1:0] data [7];
    idx  = '{CFG_NUMBER_BASE, CFG_MAX_COUNT, CFG_DELIM_COUNT, CFG_DELIM_ONE,
             CFG_DELIM_TWO, CFG_DELIM_THREE, CFG_DELIM_FOUR};
    data = '{8'(base), maxc, 8'(nsep), s0, s1, s2, s3};
    for (int i = 0; i < 7; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= data[i];
      @(posedge clk_i);
    end
    cfg_we_i   <= 1'b0;
    cur_radix  = base;
    cur_max    = maxc;
    cur_nsep   = nsep;
    cur_sep[0] = s0;
    cur_sep[1] = s1;
    cur_sep[2] = s2;
    cur_sep[3] = s3;
  endtask

  // Append a delimiter in use; now and then a stray one instead
  task automatic add_sep();
    int n;
    logic [7:0] c;
    n = (cur_nsep > NUM_DELIMS) ? int'(NUM_DELIMS) : int'(cur_nsep);
    if (n == 0 || $urandom_range(0, 29) == 0) c = 8'($urandom_range(1, 255));
    else c = cur_sep[$urandom_range(0, n - 1)];
    // a zero register never matches; send something printable instead
    if (c == CHAR_NUL) c = CHAR_MINUS;
    line_q.push_back(c);
  endtask

  // Append one number token in the current base, with optional white
  // space, sign, hex prefix and leading zero
  task automatic add_token();
    int v;
    int b;
    int digits [$];
    bit neg;
    bit prefixed;
    neg      = 1'b0;
    prefixed = 1'b0;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 1) == 0) line_q.push_back(CHAR_SPACE);
        else line_q.push_back(8'(CHAR_TAB + $urandom_range(0, 4)));
      end
    end
    if ($urandom_range(0, 5) == 0) begin
      neg = $urandom_range(0, 1);
      line_q.push_back(neg ? CHAR_MINUS : CHAR_PLUS);
    end
    v = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 1000) : $urandom_range(0, 255);
    if (neg && $urandom_range(0, 1) == 0) v = 0;
    if (cur_radix == '0) begin
      prefixed = $urandom_range(0, 1);
      b = prefixed ? 16 : 10;
    end else if (cur_radix == BASE_HEX) begin
      prefixed = ($urandom_range(0, 2) == 0);
      b = 16;
    end else if (cur_radix >= 6'd2 && cur_radix <= BASE_MAX) begin
      b = cur_radix;
    end else begin
      b = 10;
    end
    if (prefixed) begin
      line_q.push_back(CHAR_ZERO);
      // auto base only knows the lowercase prefix; try the other anyway now and then
      if (cur_radix == BASE_HEX || $urandom_range(0, 9) == 0) begin
        line_q.push_back($urandom_range(0, 1) ? CHAR_LOW_X : CHAR_UP_X);
      end else begin
        line_q.push_back(CHAR_LOW_X);
      end
      // prefix with no digits after it
      if ($urandom_range(0, 9) == 0) return;
    end
    if ($urandom_range(0, 7) == 0) line_q.push_back(CHAR_ZERO);
    do begin
      digits.push_front(v % b);
      v = v / b;
    end while (v > 0);
    foreach (digits[i]) begin
      if (digits[i] < 10) line_q.push_back(8'(CHAR_ZERO + digits[i]));
      else if ($urandom_range(0, 1) == 0) line_q.push_back(8'(CHAR_LOW_A + digits[i] - 10));
      else line_q.push_back(8'(CHAR_UP_A + digits[i] - 10));
    end
  endtask

  initial begin
    int unsigned budget;
    int ntok;
    txt.valid     <= 1'b0;
    txt.text_char <= CHAR_NUL;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_NUMBER_BASE;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    tx_steady     = 1'b0;
    chars_sent    = 0;
    cur_radix     = RST_NUMBER_BASE;
    cur_max       = RST_MAX_COUNT;
    cur_nsep      = RST_DELIM_COUNT;
    cur_sep[0]    = RST_DELIM_ONE;
    cur_sep[1]    = RST_DELIM_TWO;
    cur_sep[2]    = RST_DELIM_THREE;
    cur_sep[3]    = RST_DELIM_FOUR;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines at reset settings: empty string, auto hex and the top
    // decimal byte, signed zero and plus, doubled delimiter, value past a
    // byte, trailing delimiter
    send_text("");
    send_text("0x1f:255");
    send_text("-0:+7");
    send_text("1::2");
    send_text("300");
    send_text("1:");
    settle();

    // One register setting per pass; the first keeps reset values, the
    // next ones hit the extremes, the rest are drawn at random
    for (int setting = 0; chars_sent < TOTAL_CHARS; setting++) begin
      case (setting)
        0: ;
        // hex, four delimiters, space among them
        1: write_config(BASE_HEX, 8'd255, 3'd4, 8'h3a, 8'h2d, 8'h2e, CHAR_SPACE);
        // no byte allowed at all
        2: write_config(BASE_DEC, 8'd0, 3'd1, 8'h2c, 8'h00, 8'h00, 8'h00);
        // binary, count past four
        3: write_config(6'd2, 8'd3, 3'd7, 8'h5f, 8'h3b, 8'h2f, 8'h7c);
        // top base, no delimiters in use
        4: write_config(BASE_MAX, 8'd255, 3'd0, 8'h7a, 8'h3a, 8'h2d, 8'h2c);
        // base one is never valid
        5: write_config(6'd1, 8'd5, 3'd2, 8'h3a, 8'h2d, 8'h00, 8'h00);
        // base past 36
        6: write_config(6'd63, 8'd255, 3'd3, 8'h3a, 8'h2d, 8'h2c, 8'h00);
        // auto base with x and X as delimiters; a zero register in use
        7: write_config(6'd0, 8'd2, 3'd4, CHAR_LOW_X, CHAR_UP_X, 8'h00, 8'h3a);
        // high-bit delimiters
        8: write_config(6'd8, 8'd255, 3'd2, 8'hff, 8'h80, 8'h00, 8'h00);
        default: begin
          write_config(($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(0, 36)),
                       ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 6))
                                                   : 8'($urandom_range(0, 255)),
                       3'($urandom_range(0, 7)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
      endcase

      budget = chars_sent + SETTING_CHARS;
      while (chars_sent < budget) begin
        line_q.delete();
        tx_steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 19) == 0) begin
          // pure noise line
          repeat ($urandom_range(0, 8)) line_q.push_back(8'($urandom_range(1, 255)));
        end else begin
          // mostly well-formed lists; push past the byte limit when it is small
          if (cur_max <= 8'd12 && $urandom_range(0, 7) == 0) ntok = cur_max + $urandom_range(0, 2);
          else ntok = $urandom_range(0, 5);
          for (int t = 0; t < ntok; t++) begin
            if (t > 0) begin
              add_sep();
              if ($urandom_range(0, 24) == 0) add_sep();
            end
            // skip a token now and then to leave it empty
            if ($urandom_range(0, 29) != 0) add_token();
          end
          if ($urandom_range(0, 14) == 0) add_sep();
          if ($urandom_range(0, 11) == 0) begin
            line_q.insert($urandom_range(0, line_q.size()), 8'($urandom_range(1, 255)));
          end
        end
        foreach (line_q[i]) send_char(line_q[i]);
        send_char(CHAR_NUL);
      end
      settle();
    end

    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
